// ===== rtl/core/dfr_pkg.sv =====
// Shared types, constants and CRC helpers of the framed packet deframer.
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 56;
   localparam int MIN_LEN             = 13;
   localparam int WRAP_LEN            = 8;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [7:0]  CRC8_INIT  = 8'h77;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] CRC16_INIT = 16'h3692;
   localparam logic [15:0] CRC16_POLY = 16'h8408;
   localparam logic [7:0]  LEN_HI_MASK = 8'h03;

   localparam logic [7:0] WRAP_MAGIC [4] = '{8'h55, 8'hCC, 8'h30, 8'h75};

   // register indexes of the csr port
   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_VERSION    = 2'd1;
   localparam logic [1:0] CSR_ENVELOPE   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   typedef enum logic [1:0] {
      VD_NONE,
      VD_WAIT,
      VD_DROP,
      VD_FRAME
   } verdict_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [5:0] protocol_version;
      logic       envelope_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        first_flag;
      logic        last_flag;
      logic [15:0] drop_total;
   } result_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] drop_count;
   } status_type;

   function automatic logic [7:0] crc8_upd(input logic [7:0] c, input logic [7:0] d);
      logic [7:0] r;
      r = c ^ d;
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_upd(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfr_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/dfr_front.sv =====
// Front end: byte buffer, frame scanner with CRC checks, frame byte streaming.
`timescale 1ns / 1ps
`default_nettype none

module dfr_front #(
   parameter int MAX_FRAME_BYTES = dfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [7:0]          req_rx_byte,
   input  wire dfr_pkg::cfg_type    cfg,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output dfr_pkg::result_type      push_data,
   output dfr_pkg::status_type      status
);

   localparam int BUF = dfr_pkg::WRAP_LEN + MAX_FRAME_BYTES;
   localparam int AW  = $clog2(BUF);
   localparam int FW  = $clog2(BUF + 1);

   dfr_pkg::state_type   state_ff, state_in;
   dfr_pkg::verdict_type verdict;

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [FW-1:0] proc_ff, proc_in;
   logic [9:0]    eidx_ff, eidx_in;
   logic [7:0]    crc8_ff, crc8_in;
   logic [15:0]   crc16_ff, crc16_in;
   logic [9:0]    flen_ff, flen_in;
   logic [5:0]    ver_ff, ver_in;
   logic [15:0]   elen_ff, elen_in;
   logic          z6_ff, z6_in;
   logic [7:0]    crclo_ff, crclo_in;

   logic          accept;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    rd_data;
   logic [FW-1:0] rd_idx;
   logic [FW-1:0] off, total, kidx;
   logic          env, in_wrap, emit_last;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [FW-1:0] i);
      logic [FW:0] s;
      s = (FW+1)'(h) + (FW+1)'(i);
      if (s >= (FW+1)'(BUF)) begin
         s = s - (FW+1)'(BUF);
      end
      return AW'(s);
   endfunction

   assign env       = cfg.envelope_mode;
   assign off       = env ? FW'(dfr_pkg::WRAP_LEN) : '0;
   assign total     = off + FW'(flen_ff);
   assign in_wrap   = env && (proc_ff < FW'(dfr_pkg::WRAP_LEN));
   assign kidx      = proc_ff - off;
   assign emit_last = (eidx_ff == flen_ff - 10'd1);
   assign accept    = req_valid && req_ready;

   dfr_ram #(.WIDTH(8), .DEPTH(BUF)) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_rx_byte),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   // classify the byte at proc_ff
   always_comb begin
      verdict = dfr_pkg::VD_NONE;
      if (state_ff == dfr_pkg::ST_WALK) begin
         if (in_wrap) begin
            if (proc_ff < FW'(4) && rd_data != dfr_pkg::WRAP_MAGIC[proc_ff[1:0]]) begin
               verdict = dfr_pkg::VD_DROP;
            end else if (proc_ff == FW'(7)) begin
               if (!z6_ff || rd_data != 8'h00 || elen_ff < 16'(dfr_pkg::MIN_LEN) ||
                   elen_ff > 16'(MAX_FRAME_BYTES)) begin
                  verdict = dfr_pkg::VD_DROP;
               end else if (16'(fill_ff) - 16'(dfr_pkg::WRAP_LEN) < elen_ff) begin
                  verdict = dfr_pkg::VD_WAIT;
               end
            end else if (proc_ff + FW'(1) == fill_ff) begin
               verdict = dfr_pkg::VD_WAIT;
            end
         end else if (kidx == '0) begin
            if (rd_data != cfg.start_byte) begin
               verdict = dfr_pkg::VD_DROP;
            end else if (!env && fill_ff < FW'(4)) begin
               verdict = dfr_pkg::VD_WAIT;
            end
         end else if (kidx == FW'(3)) begin
            if (rd_data != crc8_ff || ver_ff != cfg.protocol_version ||
                flen_ff < 10'(dfr_pkg::MIN_LEN) || flen_ff > 10'(MAX_FRAME_BYTES) ||
                (env && 16'(flen_ff) != elen_ff)) begin
               verdict = dfr_pkg::VD_DROP;
            end else if (!env && 16'(fill_ff) < 16'(flen_ff)) begin
               verdict = dfr_pkg::VD_WAIT;
            end
         end else if (kidx > FW'(3) && 16'(kidx) == 16'(flen_ff) - 16'd1) begin
            if (crc16_ff != {rd_data, crclo_ff}) begin
               verdict = dfr_pkg::VD_DROP;
            end else begin
               verdict = dfr_pkg::VD_FRAME;
            end
         end
      end
   end

   // datapath next values
   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      proc_in  = proc_ff;
      eidx_in  = eidx_ff;
      crc8_in  = crc8_ff;
      crc16_in = crc16_ff;
      flen_in  = flen_ff;
      ver_in   = ver_ff;
      elen_in  = elen_ff;
      z6_in    = z6_ff;
      crclo_in = crclo_ff;
      case (state_ff)
         dfr_pkg::ST_IDLE: begin
            if (accept && fill_ff < FW'(BUF)) begin
               fill_in = fill_ff + FW'(1);
            end
         end
         dfr_pkg::ST_START: begin
            proc_in = '0;
         end
         dfr_pkg::ST_WALK: begin
            proc_in = proc_ff + FW'(1);
            if (in_wrap) begin
               case (proc_ff[2:0])
                  3'd4:    elen_in[7:0]  = rd_data;
                  3'd5:    elen_in[15:8] = rd_data;
                  3'd6:    z6_in         = (rd_data == 8'h00);
                  default: ;
               endcase
            end else begin
               if (kidx == '0) begin
                  crc8_in  = dfr_pkg::crc8_upd(dfr_pkg::CRC8_INIT, rd_data);
                  crc16_in = dfr_pkg::crc16_upd(dfr_pkg::CRC16_INIT, rd_data);
               end else if (kidx < FW'(3)) begin
                  crc8_in  = dfr_pkg::crc8_upd(crc8_ff, rd_data);
                  crc16_in = dfr_pkg::crc16_upd(crc16_ff, rd_data);
               end else if (16'(kidx) + 16'd2 < 16'(flen_ff)) begin
                  crc16_in = dfr_pkg::crc16_upd(crc16_ff, rd_data);
               end
               if (kidx == FW'(1)) begin
                  flen_in[7:0] = rd_data;
               end
               if (kidx == FW'(2)) begin
                  flen_in[9:8] = rd_data[1:0] & dfr_pkg::LEN_HI_MASK[1:0];
                  ver_in       = rd_data[7:2];
               end
               if (kidx > FW'(3) && 16'(kidx) + 16'd2 == 16'(flen_ff)) begin
                  crclo_in = rd_data;
               end
            end
            case (verdict)
               dfr_pkg::VD_DROP: begin
                  head_in = wrap_add(head_ff, FW'(1));
                  fill_in = fill_ff - FW'(1);
                  if (cnt_ff != 16'hFFFF) begin
                     cnt_in = cnt_ff + 16'd1;
                  end
               end
               dfr_pkg::VD_FRAME: eidx_in = '0;
               default: ;
            endcase
         end
         dfr_pkg::ST_EMIT_WR: begin
            if (push_ready) begin
               if (emit_last) begin
                  head_in = wrap_add(head_ff, total);
                  fill_in = fill_ff - total;
               end else begin
                  eidx_in = eidx_ff + 10'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = dfr_pkg::ST_START;
            end
         end
         dfr_pkg::ST_START: state_in = dfr_pkg::ST_WALK;
         dfr_pkg::ST_WALK: begin
            case (verdict)
               dfr_pkg::VD_WAIT:  state_in = dfr_pkg::ST_IDLE;
               dfr_pkg::VD_DROP:  state_in = (fill_ff == FW'(1)) ? dfr_pkg::ST_IDLE
                                                                 : dfr_pkg::ST_START;
               dfr_pkg::VD_FRAME: state_in = dfr_pkg::ST_EMIT_RD;
               default:           state_in = dfr_pkg::ST_WALK;
            endcase
         end
         dfr_pkg::ST_EMIT_RD: state_in = dfr_pkg::ST_EMIT_WR;
         dfr_pkg::ST_EMIT_WR: begin
            if (push_ready) begin
               if (!emit_last) begin
                  state_in = dfr_pkg::ST_EMIT_RD;
               end else if (fill_ff == total) begin
                  state_in = dfr_pkg::ST_IDLE;
               end else begin
                  state_in = dfr_pkg::ST_START;
               end
            end
         end
         default: state_in = dfr_pkg::ST_IDLE;
      endcase
   end

   // outputs and buffer port control
   always_comb begin
      req_ready = (state_ff == dfr_pkg::ST_IDLE);
      ram_we    = (state_ff == dfr_pkg::ST_IDLE) && req_valid && (fill_ff < FW'(BUF));
      ram_waddr = wrap_add(head_ff, fill_ff);
      case (state_ff)
         dfr_pkg::ST_WALK:    rd_idx = proc_ff + FW'(1);
         dfr_pkg::ST_EMIT_RD,
         dfr_pkg::ST_EMIT_WR: rd_idx = off + FW'(eidx_ff);
         default:             rd_idx = '0;
      endcase
      ram_raddr             = wrap_add(head_ff, rd_idx);
      push_valid            = (state_ff == dfr_pkg::ST_EMIT_WR);
      push_data.frame_byte  = rd_data;
      push_data.first_flag  = (eidx_ff == 10'd0);
      push_data.last_flag   = emit_last;
      push_data.drop_total  = cnt_ff;
      status.busy           = (state_ff != dfr_pkg::ST_IDLE);
      status.drop_count     = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfr_pkg::ST_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff  <= proc_in;
      eidx_ff  <= eidx_in;
      crc8_ff  <= crc8_in;
      crc16_ff <= crc16_in;
      flen_ff  <= flen_in;
      ver_ff   <= ver_in;
      elen_ff  <= elen_in;
      z6_ff    <= z6_in;
      crclo_ff <= crclo_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/dfr_queue.sv =====
// Result queue between the scanner and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module dfr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire dfr_pkg::result_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output dfr_pkg::result_type       pop_data
);

   localparam int DEPTH = dfr_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   dfr_pkg::result_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/crc_framed_packet_deframer.sv =====
// Top level of the CRC framed packet deframer: csr registers, scanner, result queue.
//
//  channel | direction | transfer when          | payload
//  req     | in        | req_valid & req_ready  | rx_byte
//  rsp     | out       | rsp_valid & rsp_ready  | frame_byte, first/last flag, drop_total
//  csr     | in        | csr_valid & csr_ready  | index, data (always ready)
//
// Scanning: after a req transfer the scanner passes a start state, then reads the buffer
//   bytes in order from the head and rescans after each drop; a found frame streams with
//   a read and a write state per byte, as the frame buffer has a single read port.
// Reset: synchronous; clears fill, head, drop counter and csr registers.
// Stalls: rsp backpressure fills the 4-entry queue, then holds the scanner.
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_packet_deframer #(
   parameter int MAX_FRAME_BYTES = dfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_first_flag,
   output logic             rsp_last_flag,
   output logic [15:0]      rsp_drop_total,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   dfr_pkg::cfg_type    cfg_ff, cfg_in;
   dfr_pkg::result_type push_data, pop_data;
   dfr_pkg::status_type status;
   logic                push_valid, push_ready;

   assign csr_ready = 1'b1;

   // csr write decode; writes are to be issued only while the block is idle (the block does not enforce this)
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dfr_pkg::CSR_START_BYTE: cfg_in.start_byte       = csr_data;
            dfr_pkg::CSR_VERSION:    cfg_in.protocol_version = csr_data[5:0];
            dfr_pkg::CSR_ENVELOPE:   cfg_in.envelope_mode    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte       <= 8'h55;
         cfg_ff.protocol_version <= 6'd1;
         cfg_ff.envelope_mode    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scanner: buffers bytes, checks frames, streams good frames
   dfr_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data),
      .status      (status)
   );

   // queue decouples result delivery from scanning
   dfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (pop_data)
   );

   assign rsp_frame_byte = pop_data.frame_byte;
   assign rsp_first_flag = pop_data.first_flag;
   assign rsp_last_flag  = pop_data.last_flag;
   assign rsp_drop_total = pop_data.drop_total;

`ifndef SYNTHESIS
   // an accepted byte always starts a scan
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> status.busy)
      else $error("scanner not busy after byte transfer");

   // drop counter never goes backward
   a_drop_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (status.drop_count >= $past(status.drop_count)))
      else $error("drop counter decreased");
`endif

endmodule

`default_nettype wire
